@@ sv/mrc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_pkg: shared constants for the masked region covariance block
// Widths of the running sums and the table that maps each product term to
// the two features it multiplies.
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int MAX_PIXELS = 65536;
  localparam int NUM_FEAT   = 8;
  localparam int NUM_PROD   = 21;
  localparam int CNT_W      = 17;
  localparam int FEAT_W     = 11;
  localparam int FSUM_W     = 27;
  localparam int PSUM_W     = 36;
  localparam int COV_W      = 29;
  localparam int IDX_W      = 5;
  localparam int DEN_W      = 34;
  localparam int ACC_W      = 64;
  localparam int MPL_W      = 27;
  localparam int ITER_W     = 7;

  localparam logic [COV_W-1:0] COV_MAX = {1'b0, {(COV_W-1){1'b1}}};
  localparam logic [COV_W-1:0] COV_MIN = {1'b1, {(COV_W-1){1'b0}}};

  localparam logic [2:0] PROD_I [NUM_PROD] = '{
    3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd2,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd6, 3'd6, 3'd7
  };
  localparam logic [2:0] PROD_J [NUM_PROD] = '{
    3'd0, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2,
    3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd4, 3'd5, 3'd6, 3'd7,
    3'd5, 3'd6, 3'd7, 3'd6, 3'd7, 3'd7
  };

endpackage

@@ sv/mrc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_if: request channels of the masked region covariance block
// One interface for incoming pixels and one for covariance results.
// ----------------------------------------------------------------------------
interface mrc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] gray_centre;
  logic [7:0] gray_left;
  logic [7:0] gray_right;
  logic [7:0] gray_up;
  logic [7:0] gray_down;
  logic       in_region;
  logic       last_pixel;

  modport source(output valid, red, green, blue, gray_centre, gray_left, gray_right,
                 gray_up, gray_down, in_region, last_pixel, input ready);
  modport sink(input valid, red, green, blue, gray_centre, gray_left, gray_right,
               gray_up, gray_down, in_region, last_pixel, output ready);
endinterface

interface mrc_res_if;
  logic                          valid;
  logic                          ready;
  logic [mrc_pkg::IDX_W-1:0]     entry_index;
  logic signed [mrc_pkg::COV_W-1:0] cov_value;
  logic                          valid_res;
  logic                          last_entry;

  modport source(output valid, entry_index, cov_value, valid_res, last_entry, input ready);
  modport sink(input valid, entry_index, cov_value, valid_res, last_entry, output ready);
endinterface

@@ sv/masked_region_covariance.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_region_covariance: region covariance descriptor over masked pixels
// Accumulates RGB and gray spatial features of marked pixels and emits 21
// sample covariances in signed fixed point on the last pixel of a region.
// ----------------------------------------------------------------------------
//  channel | dir | content
//  pix     | in  | RGB, gray centre and four neighbours, in_region, last_pixel
//  res     | out | entry_index, cov_value, valid_res, last_entry
//
//  A counted pixel passes the 11x11 multiply-add, which updates one product
//  sum per cycle. A last pixel with under two counted pixels sends one invalid
//  entry; else the denominator and each result run in the shared 64-bit adder
//  (17 + 27 multiply steps, 64 divide steps, one load, subtract, negate,
//  format and hand-off step each).
//  Reset clears all sums at once. No pixel is taken while results are pending;
//  a stalled result holds the sequencer.
// ----------------------------------------------------------------------------
module masked_region_covariance (
  input  logic      clk,
  input  logic      rst,
  mrc_pix_if.sink   pix,
  mrc_res_if.source res
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACC, ST_CHECK, ST_DEN, ST_LOADA, ST_MULA, ST_MULB,
    ST_SUB, ST_ABS, ST_DIV, ST_FIN, ST_OUT
  } state_t;

  state_t state;

  logic [7:0] p_red, p_green, p_blue, p_c, p_l, p_r, p_u, p_d;
  logic       p_last;

  logic [mrc_pkg::CNT_W-1:0]         pixel_count;
  logic signed [mrc_pkg::FSUM_W-1:0] feature_sums [mrc_pkg::NUM_FEAT];
  logic signed [mrc_pkg::PSUM_W-1:0] product_sums [mrc_pkg::NUM_PROD];

  logic [mrc_pkg::IDX_W-1:0]        k;
  logic [mrc_pkg::ITER_W-1:0]       iter;
  logic signed [mrc_pkg::ACC_W-1:0] acc;
  logic signed [mrc_pkg::ACC_W-1:0] tmp;
  logic signed [mrc_pkg::ACC_W-1:0] mcand;
  logic [mrc_pkg::MPL_W-1:0]        mplier;
  logic [mrc_pkg::DEN_W-1:0]        den;
  logic [mrc_pkg::DEN_W:0]          rem;
  logic [mrc_pkg::ACC_W-1:0]        dvd;
  logic signed [mrc_pkg::FSUM_W-1:0] si;
  logic                             neg;

  logic                             out_valid;
  logic [mrc_pkg::IDX_W-1:0]        out_index;
  logic [mrc_pkg::COV_W-1:0]        out_cov;
  logic                             out_vres;
  logic                             out_last;

  logic signed [mrc_pkg::FEAT_W-1:0] feat [mrc_pkg::NUM_FEAT];
  logic signed [2*mrc_pkg::FEAT_W-1:0] prod;
  logic [mrc_pkg::ACC_W-1:0] op_a, op_b, sum;
  logic                      cin;
  logic [mrc_pkg::DEN_W:0]   rem_sh;
  logic signed [mrc_pkg::FSUM_W-1:0] sj;
  logic [mrc_pkg::COV_W-1:0] cov_clamped;

  assign pix.ready       = (state == ST_IDLE);
  assign res.valid       = out_valid;
  assign res.entry_index = out_index;
  assign res.cov_value   = out_cov;
  assign res.valid_res   = out_vres;
  assign res.last_entry  = out_last;

  always_comb begin
    feat[0] = mrc_pkg::FEAT_W'({3'b0, p_red});
    feat[1] = mrc_pkg::FEAT_W'({3'b0, p_green});
    feat[2] = mrc_pkg::FEAT_W'({3'b0, p_blue});
    feat[3] = mrc_pkg::FEAT_W'({3'b0, p_c});
    feat[4] = {3'b0, p_r} - {3'b0, p_l};
    feat[5] = {3'b0, p_d} - {3'b0, p_u};
    feat[6] = {3'b0, p_r} + {3'b0, p_l} - {2'b0, p_c, 1'b0};
    feat[7] = {3'b0, p_d} + {3'b0, p_u} - {2'b0, p_c, 1'b0};
  end

  assign prod   = feat[mrc_pkg::PROD_I[k]] * feat[mrc_pkg::PROD_J[k]];
  assign sj     = feature_sums[mrc_pkg::PROD_J[k]];
  assign rem_sh = {rem[mrc_pkg::DEN_W-1:0], dvd[mrc_pkg::ACC_W-1]};

  always_comb begin
    op_a = acc;
    op_b = '0;
    cin  = 1'b0;
    case (state) inside
      ST_DEN, ST_MULA, ST_MULB: begin
        op_b = mplier[0] ? mcand : '0;
      end
      ST_SUB: begin
        op_a = tmp;
        op_b = ~acc;
        cin  = 1'b1;
      end
      ST_ABS: begin
        op_a = '0;
        op_b = ~acc;
        cin  = 1'b1;
      end
      ST_DIV: begin
        op_a = mrc_pkg::ACC_W'(rem_sh);
        op_b = ~mrc_pkg::ACC_W'(den);
        cin  = 1'b1;
      end
      default: begin
        op_b = '0;
      end
    endcase
    sum = op_a + op_b + mrc_pkg::ACC_W'(cin);
  end

  always_comb begin
    if (!neg) begin
      if (dvd > mrc_pkg::ACC_W'(mrc_pkg::COV_MAX)) cov_clamped = mrc_pkg::COV_MAX;
      else cov_clamped = dvd[mrc_pkg::COV_W-1:0];
    end else begin
      if (dvd > mrc_pkg::ACC_W'(mrc_pkg::COV_MIN)) cov_clamped = mrc_pkg::COV_MIN;
      else cov_clamped = -dvd[mrc_pkg::COV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      pixel_count <= '0;
      for (int f = 0; f < mrc_pkg::NUM_FEAT; f++) feature_sums[f] <= '0;
      for (int q = 0; q < mrc_pkg::NUM_PROD; q++) product_sums[q] <= '0;
      k    <= '0;
      iter <= '0;
    end else begin
      unique case (state) inside
        ST_IDLE: begin
          if (pix.valid) begin
            p_red   <= pix.red;
            p_green <= pix.green;
            p_blue  <= pix.blue;
            p_c     <= pix.gray_centre;
            p_l     <= pix.gray_left;
            p_r     <= pix.gray_right;
            p_u     <= pix.gray_up;
            p_d     <= pix.gray_down;
            p_last  <= pix.last_pixel;
            k       <= '0;
            if (pix.in_region &&
                pixel_count < mrc_pkg::CNT_W'(mrc_pkg::MAX_PIXELS)) begin
              state <= ST_ACC;
            end else begin
              state <= ST_CHECK;
            end
          end
        end
        ST_ACC: begin
          product_sums[k] <= product_sums[k] + mrc_pkg::PSUM_W'(prod);
          if (k < mrc_pkg::IDX_W'(mrc_pkg::NUM_FEAT)) begin
            feature_sums[k[2:0]] <= feature_sums[k[2:0]] +
                                    mrc_pkg::FSUM_W'(feat[k[2:0]]);
          end
          if (k == mrc_pkg::IDX_W'(mrc_pkg::NUM_PROD - 1)) begin
            pixel_count <= pixel_count + 1'b1;
            state       <= ST_CHECK;
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_CHECK: begin
          k <= '0;
          if (!p_last) begin
            state <= ST_IDLE;
          end else if (pixel_count <= mrc_pkg::CNT_W'(1)) begin
            out_valid <= 1'b1;
            out_index <= '0;
            out_cov   <= '0;
            out_vres  <= 1'b0;
            out_last  <= 1'b1;
            state     <= ST_OUT;
          end else begin
            acc    <= '0;
            mcand  <= mrc_pkg::ACC_W'(pixel_count);
            mplier <= mrc_pkg::MPL_W'(pixel_count - 1'b1);
            iter   <= mrc_pkg::ITER_W'(mrc_pkg::CNT_W);
            state  <= ST_DEN;
          end
        end
        ST_DEN, ST_MULB: begin
          acc    <= sum;
          mcand  <= mcand <<< 1;
          mplier <= mplier >> 1;
          iter   <= iter - 1'b1;
          if (iter == mrc_pkg::ITER_W'(1)) begin
            if (state == ST_DEN) begin
              den   <= sum[mrc_pkg::DEN_W-1:0];
              state <= ST_LOADA;
            end else begin
              state <= ST_SUB;
            end
          end
        end
        ST_MULA: begin
          if (iter == mrc_pkg::ITER_W'(1)) begin
            tmp    <= sum;
            acc    <= '0;
            mcand  <= sj[mrc_pkg::FSUM_W-1] ? -mrc_pkg::ACC_W'(si) : mrc_pkg::ACC_W'(si);
            mplier <= sj[mrc_pkg::FSUM_W-1] ? mrc_pkg::MPL_W'(-sj) : mrc_pkg::MPL_W'(sj);
            iter   <= mrc_pkg::ITER_W'(mrc_pkg::MPL_W);
            state  <= ST_MULB;
          end else begin
            acc    <= sum;
            mcand  <= mcand <<< 1;
            mplier <= mplier >> 1;
            iter   <= iter - 1'b1;
          end
        end
        ST_LOADA: begin
          acc    <= '0;
          mcand  <= mrc_pkg::ACC_W'(product_sums[k]);
          mplier <= mrc_pkg::MPL_W'(pixel_count);
          si     <= feature_sums[mrc_pkg::PROD_I[k]];
          iter   <= mrc_pkg::ITER_W'(mrc_pkg::CNT_W);
          state  <= ST_MULA;
        end
        ST_SUB: begin
          acc   <= sum;
          neg   <= sum[mrc_pkg::ACC_W-1];
          state <= ST_ABS;
        end
        ST_ABS: begin
          dvd   <= neg ? (sum << 8) : (acc << 8);
          rem   <= '0;
          iter  <= mrc_pkg::ITER_W'(mrc_pkg::ACC_W);
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (!sum[mrc_pkg::ACC_W-1]) begin
            rem <= sum[mrc_pkg::DEN_W:0];
            dvd <= {dvd[mrc_pkg::ACC_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            dvd <= {dvd[mrc_pkg::ACC_W-2:0], 1'b0};
          end
          iter <= iter - 1'b1;
          if (iter == mrc_pkg::ITER_W'(1)) state <= ST_FIN;
        end
        ST_FIN: begin
          out_valid <= 1'b1;
          out_index <= k;
          out_cov   <= cov_clamped;
          out_vres  <= 1'b1;
          out_last  <= (k == mrc_pkg::IDX_W'(mrc_pkg::NUM_PROD - 1));
          state     <= ST_OUT;
        end
        ST_OUT: begin
          if (res.ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              pixel_count <= '0;
              for (int f = 0; f < mrc_pkg::NUM_FEAT; f++) feature_sums[f] <= '0;
              for (int q = 0; q < mrc_pkg::NUM_PROD; q++) product_sums[q] <= '0;
              state <= ST_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= ST_LOADA;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(pix.ready && res.valid))
    else $error("pixel taken while a result is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pixel_count <= mrc_pkg::CNT_W'(mrc_pkg::MAX_PIXELS))
    else $error("pixel count beyond limit");

  a_clear_after_run: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ready && res.last_entry) |=> (pixel_count == '0))
    else $error("state not cleared after run");

  a_short_run: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.valid_res) |-> (res.last_entry && res.entry_index == '0))
    else $error("invalid result not single");
`endif

endmodule
